// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/ustc_pkg.sv =====
// ----------------------------------------------------------------------------
// ustc_pkg
// Types and constants of the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package ustc_pkg;

  localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // reciprocals: seconds/128 by 675 (>> 35), days by 7 (>> 19),
  // seconds of day by 3600 (>> 29), seconds of hour by 60 (>> 18)
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [16:0] WEEK_RECIP = 17'd74899;
  localparam logic [17:0] HOUR_RECIP = 18'd149131;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4     = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100   = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400   = 9'd370;
  localparam logic [6:0]  CENTURY_LAST   = 7'd99;
  localparam logic [8:0]  QUAD_CENT_LAST = 9'd399;
  localparam logic [2:0]  WEEKDAY_ADJ    = 3'd3;
  localparam logic [3:0]  DAYS_PER_WEEK  = 4'd7;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_NOV = 4'd11;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  localparam logic [11:0] BASE_YEAR_RST = 12'd2000;
  localparam logic        REG_BASE_YEAR = 1'b0;

  typedef struct packed {
    logic load;
    logic day_quo;
    logic day_rem;
    logic hour_quo;
    logic hour_rem;
    logic min_quo;
    logic min_rem;
    logic year_step;
    logic month_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } dp_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                               len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default:                                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/ustc_datapath.sv =====
// ----------------------------------------------------------------------------
// ustc_datapath
// Day split, time-of-day digits, year and month walk, weekday residue.
// ----------------------------------------------------------------------------
module ustc_datapath (
  input  logic               clk_i,
  input  ustc_pkg::ctrl_cmd_t cmd_i,
  output ustc_pkg::dp_sts_t   sts_o,
  input  logic [31:0]        unix_seconds_i,
  input  logic [11:0]        base_year_i,
  output logic [4:0]         hours_o,
  output logic [5:0]         minutes_o,
  output logic [5:0]         secs_o,
  output logic [2:0]         weekday_o,
  output logic [7:0]         year_offset_o,
  output logic [3:0]         month_number_o,
  output logic [4:0]         day_of_month_o
);
  import ustc_pkg::*;

  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [2:0]  wk_q, wk_d;
  logic [2:0]  wd_q, wd_d;
  logic [11:0] year_q, year_d;
  logic [1:0]  ym4_q, ym4_d;
  logic [6:0]  ym100_q, ym100_d;
  logic [8:0]  ym400_q, ym400_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  hrs_q, hrs_d;
  logic [5:0]  mins_q, mins_d;

  logic [50:0] day_prod;
  logic [33:0] day_back;
  logic [32:0] week_prod;
  logic [34:0] hour_prod;
  logic [16:0] hour_back;
  logic [24:0] min_prod;
  logic [16:0] min_back;
  logic [15:0] days;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  wd_sum;
  logic [2:0]  wd_fold;

  assign days = num_q[15:0];

  assign day_prod  = 51'(num_q[31:7]) * 51'(DAY_RECIP);
  assign day_back  = 34'(days) * 34'(SECS_PER_DAY);
  assign week_prod = 33'(days) * 33'(WEEK_RECIP);
  assign hour_prod = 35'(rem_q) * 35'(HOUR_RECIP);
  assign hour_back = 17'(hrs_q) * SECS_PER_HOUR;
  assign min_prod  = 25'(rem_q[11:0]) * 25'(MIN_RECIP);
  assign min_back  = 17'(mins_q) * SECS_PER_MIN;

  assign leap = ((ym4_q == 2'd0) && (ym100_q != 7'd0)) || (ym400_q == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_q, leap);

  assign sts_o.year_fits  = days < {7'd0, ylen};
  assign sts_o.month_fits = (days < {11'd0, mlen}) || (month_q == MONTH_DEC);

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    wk_d    = wk_q;
    wd_d    = wd_q;
    year_d  = year_q;
    ym4_d   = ym4_q;
    ym100_d = ym100_q;
    ym400_d = ym400_q;
    month_d = month_q;
    hrs_d   = hrs_q;
    mins_d  = mins_q;
    if (cmd_i.load) begin
      num_d   = unix_seconds_i;
      rem_d   = unix_seconds_i[16:0];
      wk_d    = '0;
      wd_d    = '0;
      year_d  = EPOCH_YEAR;
      ym4_d   = EPOCH_MOD4;
      ym100_d = EPOCH_MOD100;
      ym400_d = EPOCH_MOD400;
      month_d = MONTH_JAN;
      hrs_d   = '0;
      mins_d  = '0;
    end else if (cmd_i.day_quo) begin
      num_d = {16'd0, day_prod[50:35]};
    end else if (cmd_i.day_rem) begin
      rem_d = rem_q - day_back[16:0];
      wk_d  = week_prod[21:19];
    end else if (cmd_i.hour_quo) begin
      hrs_d = hour_prod[33:29];
      // days - 7q equals days + q modulo 8
      wd_d  = days[2:0] + wk_q;
    end else if (cmd_i.hour_rem) begin
      rem_d = rem_q - hour_back;
    end else if (cmd_i.min_quo) begin
      mins_d = min_prod[23:18];
    end else if (cmd_i.min_rem) begin
      rem_d = rem_q - min_back;
    end else if (cmd_i.year_step) begin
      num_d   = {16'd0, 16'(days - {7'd0, ylen})};
      year_d  = year_q + 12'd1;
      ym4_d   = ym4_q + 2'd1;
      ym100_d = (ym100_q == CENTURY_LAST) ? 7'd0 : ym100_q + 7'd1;
      ym400_d = (ym400_q == QUAD_CENT_LAST) ? 9'd0 : ym400_q + 9'd1;
    end else if (cmd_i.month_step) begin
      num_d   = {16'd0, 16'(days - {11'd0, mlen})};
      month_d = month_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rem_q   <= rem_d;
    wk_q    <= wk_d;
    wd_q    <= wd_d;
    year_q  <= year_d;
    ym4_q   <= ym4_d;
    ym100_q <= ym100_d;
    ym400_q <= ym400_d;
    month_q <= month_d;
    hrs_q   <= hrs_d;
    mins_q  <= mins_d;
  end

  assign wd_sum  = {1'b0, wd_q} + {1'b0, WEEKDAY_ADJ};
  assign wd_fold = (wd_sum >= DAYS_PER_WEEK) ? 3'(wd_sum - DAYS_PER_WEEK) : wd_sum[2:0];

  assign hours_o        = hrs_q;
  assign minutes_o      = mins_q;
  assign secs_o         = rem_q[5:0];
  assign weekday_o      = wd_fold + 3'd1;
  assign year_offset_o  = year_q[7:0] - base_year_i[7:0];
  assign month_number_o = month_q;
  assign day_of_month_o = days[4:0] + 5'd1;

endmodule

// ===== sv/ustc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ustc_ctrl
// Sequencer: day division, hour and minute digits, year walk, month walk.
// ----------------------------------------------------------------------------
module ustc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output ustc_pkg::ctrl_cmd_t cmd_o,
  input  ustc_pkg::dp_sts_t   sts_i
);
  import ustc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DAYQ  = 10'b0000000010,
    S_DAYR  = 10'b0000000100,
    S_HOURQ = 10'b0000001000,
    S_HOURR = 10'b0000010000,
    S_MINQ  = 10'b0000100000,
    S_MINR  = 10'b0001000000,
    S_YEAR  = 10'b0010000000,
    S_MONTH = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DAYQ;
        end
      end
      S_DAYQ: begin
        cmd_o.day_quo = 1'b1;
        state_d       = S_DAYR;
      end
      S_DAYR: begin
        cmd_o.day_rem = 1'b1;
        state_d       = S_HOURQ;
      end
      S_HOURQ: begin
        cmd_o.hour_quo = 1'b1;
        state_d        = S_HOURR;
      end
      S_HOURR: begin
        cmd_o.hour_rem = 1'b1;
        state_d        = S_MINQ;
      end
      S_MINQ: begin
        cmd_o.min_quo = 1'b1;
        state_d       = S_MINR;
      end
      S_MINR: begin
        cmd_o.min_rem = 1'b1;
        state_d       = S_YEAR;
      end
      S_YEAR: begin
        if (sts_i.year_fits) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts_i.month_fits) begin
          state_d = S_DONE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

endmodule

// ===== sv/unix_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts seconds since 1970-01-01 00:00:00 to Gregorian date and time.
// ----------------------------------------------------------------------------
//  channel  | handshake                       | payload
//  ---------+---------------------------------+--------------------------------
//  input    | start high, busy low            | unix_seconds_i
//  result   | done_o high for one cycle       | hours_o .. day_of_month_o
//  config   | psel, penable, pwrite, pready   | paddr, pwdata (base year)
//
//  After accept, the day quotient, day remainder, hour quotient, hour remainder,
//  minute quotient and minute remainder steps split the seconds by reciprocal
//  products; the year walk then steps one year per cycle over the whole years
//  past 1970 (0..136), and the month walk over the month index (0..11).
//  A new item is taken once busy falls, the cycle after done_o; results cannot
//  be stalled. Reset returns the sequencer to idle and the base year to 2000.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds_i,
  output logic        done_o,
  output logic [4:0]  hours_o,
  output logic [5:0]  minutes_o,
  output logic [5:0]  secs_o,
  output logic [2:0]  weekday_o,
  output logic [7:0]  year_offset_o,
  output logic [3:0]  month_number_o,
  output logic [4:0]  day_of_month_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ustc_pkg::*;

  ctrl_cmd_t   cmd;
  dp_sts_t     sts;
  logic [11:0] base_year_q;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == REG_BASE_YEAR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= BASE_YEAR_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      base_year_q <= pwdata[11:0];
    end
  end

  assign prdata = reg_hit ? {20'd0, base_year_q} : 32'd0;

  ustc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  ustc_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .unix_seconds_i(unix_seconds_i),
    .base_year_i   (base_year_q),
    .hours_o       (hours_o),
    .minutes_o     (minutes_o),
    .secs_o        (secs_o),
    .weekday_o     (weekday_o),
    .year_offset_o (year_offset_o),
    .month_number_o(month_number_o),
    .day_of_month_o(day_of_month_o)
  );

endmodule

// ===== sv/ustc_checker.sv =====
// ----------------------------------------------------------------------------
// ustc_checker
// Port-level checks of the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ustc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [4:0] hours_o,
  input logic [5:0] minutes_o,
  input logic [5:0] secs_o,
  input logic [2:0] weekday_o,
  input logic [3:0] month_number_o,
  input logic [4:0] day_of_month_o
);

  logic time_ok;
  logic date_ok;

  assign time_ok = (hours_o < 5'd24) && (minutes_o < 6'd60) && (secs_o < 6'd60);
  assign date_ok = (weekday_o != 3'd0) && (month_number_o != 4'd0) &&
                   (month_number_o < 4'd13) && (day_of_month_o != 5'd0);

  `CHK_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `CHK_ASSERT(a_done_once, done_o |=> (!done_o && !busy), "result not single or busy held")
  `CHK_ASSERT(a_time_range, done_o |-> time_ok, "time of day out of range")
  `CHK_ASSERT(a_date_range, done_o |-> date_ok, "date field out of range")
  `CHK_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (!busy && !done_o), "not idle in reset")

endmodule

bind unix_seconds_to_calendar ustc_checker u_ustc_checker (.*);
